@@ sv/i2c_mras_pkg.sv @@
// ----------------------------------------------------------------------------
// i2c_mras_pkg
// Shared codes and limits for the I2C master register access sequencer.
// ----------------------------------------------------------------------------
package i2c_mras_pkg;

	// Largest accepted read length
	localparam logic [15:0] MAX_READ_LEN = 16'd255;

	// Request kinds on the func field
	typedef enum logic [1:0] {
		FUNC_START_WR = 2'd0,
		FUNC_START_RD = 2'd1,
		FUNC_EVENT    = 2'd2,
		FUNC_UNUSED   = 2'd3
	} func_t;

	// Acknowledge control actions
	typedef enum logic [1:0] {
		ACK_KEEP = 2'd0,
		ACK_ON   = 2'd1,
		ACK_OFF  = 2'd2
	} ack_t;

	// Transaction phases
	typedef enum logic [3:0] {
		PH_IDLE        = 4'd0,
		PH_START       = 4'd1,
		PH_ADDR_W      = 4'd2,
		PH_REG         = 4'd3,
		PH_WDATA       = 4'd4,
		PH_RESTART     = 4'd5,
		PH_ADDR_R      = 4'd6,
		PH_ADDR_R_WAIT = 4'd7,
		PH_READ        = 4'd8,
		PH_STOP        = 4'd9
	} phase_t;

endpackage

@@ sv/i2c_master_register_access_sequencer.sv @@
// ----------------------------------------------------------------------------
// i2c_master_register_access_sequencer
// Turns byte-level I2C controller status events into register transaction
// actions: start, address, register, data or repeated-start read, stop.
// ----------------------------------------------------------------------------
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request per handshake:
//   start write, start read, or a status flag event from the controller.
//   Output channel (out_valid / out_stall) returns exactly one result per
//   request: what to drive on the controller (tx byte, start, stop, ack
//   control), any received byte with its index, and completion / busy.
//   Start requests are refused (accepted = 0) while a transaction runs, and a
//   read length of zero or above MAX_READ_LEN is refused too.
//   The request is captured in the input stage, then the phase logic runs and
//   the result lands in the output register.
//   Throughput is 1 request per cycle while out_stall is low; the phase
//   register update is the only loop.
//   Reset (arst_n low) empties both stages and returns to idle, not busy.
//   When the receiver stalls, the output register holds its result; one more
//   request may sit in the input stage, after which in_stall rises and stays
//   high until the output is taken.
// ----------------------------------------------------------------------------
module i2c_master_register_access_sequencer (
	input  logic       clk,
	input  logic       arst_n,
	// request channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] func,
	input  logic [7:0] dev_addr,
	input  logic [7:0] reg_addr,
	input  logic [7:0] write_value,
	input  logic [7:0] read_len,
	input  logic       flag_sb,
	input  logic       flag_addr,
	input  logic       flag_txe,
	input  logic       flag_btf,
	input  logic       flag_rxne,
	input  logic [7:0] rx_byte,
	// result channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic       accepted,
	output logic       tx_valid,
	output logic [7:0] tx_data,
	output logic       gen_start,
	output logic       gen_stop,
	output logic [1:0] ack_action,
	output logic       rx_valid,
	output logic [7:0] rx_data,
	output logic [7:0] rx_index,
	output logic       done_res,
	output logic       busy_out
);

	// ---------------- input stage ----------------
	logic       valid_s1;
	logic [1:0] func_s1;
	logic [7:0] dev_addr_s1;
	logic [7:0] reg_addr_s1;
	logic [7:0] write_value_s1;
	logic [7:0] read_len_s1;
	logic       flag_sb_s1;
	logic       flag_addr_s1;
	logic       flag_txe_s1;
	logic       flag_btf_s1;
	logic       flag_rxne_s1;
	logic [7:0] rx_byte_s1;

	// ---------------- transaction state ----------------
	i2c_mras_pkg::phase_t phase_q, phase_nxt;
	logic [7:0] device_q, device_nxt;
	logic [7:0] register_q, register_nxt;
	logic [7:0] data_q, data_nxt;
	logic [7:0] len_total_q, len_total_nxt;
	logic [7:0] byte_idx_q, byte_idx_nxt;
	logic       read_mode_q, read_mode_nxt;
	logic       busy_q, busy_nxt;

	// ---------------- result values ----------------
	logic       acc_c;
	logic       txv_c;
	logic [7:0] txd_c;
	logic       gs_c;
	logic       gp_c;
	i2c_mras_pkg::ack_t ack_c;
	logic       rxv_c;
	logic [7:0] rxd_c;
	logic [7:0] rxi_c;
	logic       dn_c;

	logic       out_valid_q;
	logic       adv;            // input stage moves into output register
	logic       len_ok;
	logic [8:0] idx_inc;        // byte_idx + 1, wrapped to 8 bits then widened

	// Output register can take a new result when empty or being drained.
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload capture, no reset needed
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1        <= func;
			dev_addr_s1    <= dev_addr;
			reg_addr_s1    <= reg_addr;
			write_value_s1 <= write_value;
			read_len_s1    <= read_len;
			flag_sb_s1     <= flag_sb;
			flag_addr_s1   <= flag_addr;
			flag_txe_s1    <= flag_txe;
			flag_btf_s1    <= flag_btf;
			flag_rxne_s1   <= flag_rxne;
			rx_byte_s1     <= rx_byte;
		end
	end

	assign len_ok  = (read_len_s1 != 8'd0) &&
		({8'd0, read_len_s1} <= i2c_mras_pkg::MAX_READ_LEN);
	assign idx_inc = {1'b0, byte_idx_q + 8'd1};

	// Next-state logic
	always_comb begin
		phase_nxt     = phase_q;
		device_nxt    = device_q;
		register_nxt  = register_q;
		data_nxt      = data_q;
		len_total_nxt = len_total_q;
		byte_idx_nxt  = byte_idx_q;
		read_mode_nxt = read_mode_q;
		busy_nxt      = busy_q;
		case (i2c_mras_pkg::func_t'(func_s1))
			i2c_mras_pkg::FUNC_START_WR: begin
				if (!busy_q) begin
					device_nxt    = dev_addr_s1;
					register_nxt  = reg_addr_s1;
					data_nxt      = write_value_s1;
					len_total_nxt = 8'd1;
					byte_idx_nxt  = 8'd0;
					read_mode_nxt = 1'b0;
					busy_nxt      = 1'b1;
					phase_nxt     = i2c_mras_pkg::PH_START;
				end
			end
			i2c_mras_pkg::FUNC_START_RD: begin
				if (!busy_q && len_ok) begin
					device_nxt    = dev_addr_s1;
					register_nxt  = reg_addr_s1;
					len_total_nxt = read_len_s1;
					byte_idx_nxt  = 8'd0;
					read_mode_nxt = 1'b1;
					busy_nxt      = 1'b1;
					phase_nxt     = i2c_mras_pkg::PH_START;
				end
			end
			i2c_mras_pkg::FUNC_EVENT: begin
				case (phase_q)
					i2c_mras_pkg::PH_START: begin
						if (flag_sb_s1) phase_nxt = i2c_mras_pkg::PH_ADDR_W;
					end
					i2c_mras_pkg::PH_ADDR_W: begin
						if (flag_addr_s1) phase_nxt = i2c_mras_pkg::PH_REG;
					end
					i2c_mras_pkg::PH_REG: begin
						if (flag_txe_s1) begin
							phase_nxt = read_mode_q ? i2c_mras_pkg::PH_RESTART
								: i2c_mras_pkg::PH_WDATA;
						end
					end
					i2c_mras_pkg::PH_WDATA: begin
						if (flag_btf_s1) phase_nxt = i2c_mras_pkg::PH_STOP;
					end
					i2c_mras_pkg::PH_RESTART: begin
						if (flag_btf_s1) phase_nxt = i2c_mras_pkg::PH_ADDR_R;
					end
					i2c_mras_pkg::PH_ADDR_R: begin
						if (flag_sb_s1) phase_nxt = i2c_mras_pkg::PH_ADDR_R_WAIT;
					end
					i2c_mras_pkg::PH_ADDR_R_WAIT: begin
						if (flag_addr_s1) phase_nxt = i2c_mras_pkg::PH_READ;
					end
					i2c_mras_pkg::PH_READ: begin
						if (flag_rxne_s1) begin
							byte_idx_nxt = idx_inc[7:0];
							if (idx_inc >= {1'b0, len_total_q}) begin
								busy_nxt  = 1'b0;
								phase_nxt = i2c_mras_pkg::PH_IDLE;
							end
						end
					end
					i2c_mras_pkg::PH_STOP: begin
						if (flag_btf_s1) begin
							busy_nxt  = 1'b0;
							phase_nxt = i2c_mras_pkg::PH_IDLE;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	// Result logic
	always_comb begin
		acc_c = 1'b0;
		txv_c = 1'b0;
		txd_c = 8'd0;
		gs_c  = 1'b0;
		gp_c  = 1'b0;
		ack_c = i2c_mras_pkg::ACK_KEEP;
		rxv_c = 1'b0;
		rxd_c = 8'd0;
		rxi_c = 8'd0;
		dn_c  = 1'b0;
		case (i2c_mras_pkg::func_t'(func_s1))
			i2c_mras_pkg::FUNC_START_WR: begin
				if (!busy_q) begin
					acc_c = 1'b1;
					gs_c  = 1'b1;
				end
			end
			i2c_mras_pkg::FUNC_START_RD: begin
				if (!busy_q && len_ok) begin
					acc_c = 1'b1;
					gs_c  = 1'b1;
				end
			end
			i2c_mras_pkg::FUNC_EVENT: begin
				case (phase_q)
					i2c_mras_pkg::PH_START: begin
						if (flag_sb_s1) begin
							txv_c = 1'b1;
							txd_c = device_q;
						end
					end
					i2c_mras_pkg::PH_REG: begin
						if (flag_txe_s1) begin
							txv_c = 1'b1;
							txd_c = register_q;
						end
					end
					i2c_mras_pkg::PH_WDATA: begin
						if (flag_btf_s1) begin
							txv_c = 1'b1;
							txd_c = data_q;
						end
					end
					i2c_mras_pkg::PH_RESTART: begin
						if (flag_btf_s1) gs_c = 1'b1;
					end
					i2c_mras_pkg::PH_ADDR_R: begin
						if (flag_sb_s1) begin
							txv_c = 1'b1;
							txd_c = device_q | 8'd1;
						end
					end
					i2c_mras_pkg::PH_ADDR_R_WAIT: begin
						if (flag_addr_s1) begin
							// single-byte read: NACK and stop right away
							if (len_total_q == 8'd1) begin
								ack_c = i2c_mras_pkg::ACK_OFF;
								gp_c  = 1'b1;
							end else begin
								ack_c = i2c_mras_pkg::ACK_ON;
							end
						end
					end
					i2c_mras_pkg::PH_READ: begin
						if (flag_rxne_s1) begin
							rxv_c = 1'b1;
							rxd_c = rx_byte_s1;
							rxi_c = byte_idx_q;
							// next byte is the last one
							if (idx_inc + 9'd1 == {1'b0, len_total_q}) begin
								ack_c = i2c_mras_pkg::ACK_OFF;
								gp_c  = 1'b1;
							end
							if (idx_inc >= {1'b0, len_total_q}) begin
								ack_c = i2c_mras_pkg::ACK_ON;
								dn_c  = 1'b1;
							end
						end
					end
					i2c_mras_pkg::PH_STOP: begin
						if (flag_btf_s1) begin
							gp_c  = 1'b1;
							ack_c = i2c_mras_pkg::ACK_ON;
							dn_c  = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= i2c_mras_pkg::PH_IDLE;
			device_q    <= 8'd0;
			register_q  <= 8'd0;
			data_q      <= 8'd0;
			len_total_q <= 8'd0;
			byte_idx_q  <= 8'd0;
			read_mode_q <= 1'b0;
			busy_q      <= 1'b0;
		end else if (valid_s1 && adv) begin
			phase_q     <= phase_nxt;
			device_q    <= device_nxt;
			register_q  <= register_nxt;
			data_q      <= data_nxt;
			len_total_q <= len_total_nxt;
			byte_idx_q  <= byte_idx_nxt;
			read_mode_q <= read_mode_nxt;
			busy_q      <= busy_nxt;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			accepted   <= acc_c;
			tx_valid   <= txv_c;
			tx_data    <= txd_c;
			gen_start  <= gs_c;
			gen_stop   <= gp_c;
			ack_action <= ack_c;
			rx_valid   <= rxv_c;
			rx_data    <= rxd_c;
			rx_index   <= rxi_c;
			done_res   <= dn_c;
			busy_out   <= busy_nxt;
		end
	end

	assign out_valid = out_valid_q;

	// ---------------- assertions ----------------
	a_idle_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == i2c_mras_pkg::PH_IDLE) == !busy_q)
		else $error("phase and busy flag disagree");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> busy_out)
		else $error("accepted start without busy");

	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_out)
		else $error("done while still busy");

	a_tx_rx_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(tx_valid && rx_valid))
		else $error("tx and rx in one result");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q)
		else $error("input stalled with room downstream");

endmodule

@@ tb/sv/i2c_master_register_access_sequencer_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_master_register_access_sequencer_tb
// Self-checking bench for the I2C register transaction sequencer: it drives
// start-write, start-read and controller flag event requests, tracks the
// transaction phase in a local model, and checks every result field in order.
// ----------------------------------------------------------------------------
module i2c_master_register_access_sequencer_tb;

	localparam int CLK_HALF     = 5;
	localparam int LIMIT_CYCLES = 500_000;
	localparam int HOLD_CYCLES  = 60;      // long receiver hold-off
	localparam int SETTLE       = 8;       // margin after the final drain
	localparam int RANDOM_REQS  = 450;

	// Status flag masks, packed as {sb, addr, txe, btf, rxne}
	localparam logic [4:0] FL_SB   = 5'b10000;
	localparam logic [4:0] FL_ADDR = 5'b01000;
	localparam logic [4:0] FL_TXE  = 5'b00100;
	localparam logic [4:0] FL_BTF  = 5'b00010;
	localparam logic [4:0] FL_RXNE = 5'b00001;
	localparam logic [4:0] FL_ALL  = 5'b11111;

	// One request as it crosses the input handshake
	typedef struct {
		i2c_mras_pkg::func_t func;
		logic [7:0] dev_addr;
		logic [7:0] reg_addr;
		logic [7:0] write_value;
		logic [7:0] read_len;
		logic [4:0] flags;
		logic [7:0] rx_byte;
	} seq_req_t;

	// What the block should report for one request
	typedef struct {
		logic       accepted;
		logic       tx_valid;
		logic [7:0] tx_data;
		logic       gen_start;
		logic       gen_stop;
		i2c_mras_pkg::ack_t ack;
		logic       rx_valid;
		logic [7:0] rx_data;
		logic [7:0] rx_index;
		logic       done;
		logic       busy;
	} xfer_action_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [1:0] func;
	logic [7:0] dev_addr;
	logic [7:0] reg_addr;
	logic [7:0] write_value;
	logic [7:0] read_len;
	logic       flag_sb;
	logic       flag_addr;
	logic       flag_txe;
	logic       flag_btf;
	logic       flag_rxne;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_stall;
	logic       accepted;
	logic       tx_valid;
	logic [7:0] tx_data;
	logic       gen_start;
	logic       gen_stop;
	logic [1:0] ack_action;
	logic       rx_valid;
	logic [7:0] rx_data;
	logic [7:0] rx_index;
	logic       done_res;
	logic       busy_out;

	// Local copy of the sequencer state
	i2c_mras_pkg::phase_t seq_phase;
	logic [7:0] dev_byte;
	logic [7:0] reg_byte;
	logic [7:0] wr_byte;
	logic [7:0] len_total;
	logic [7:0] rx_count;
	logic       rd_mode;
	logic       seq_busy;

	xfer_action_t expected_actions[$];

	// Run bookkeeping
	int unsigned mismatches   = 0;
	int unsigned reqs_sent    = 0;
	int unsigned results_seen = 0;
	int unsigned reads_done   = 0;
	int unsigned writes_done  = 0;
	int unsigned in_stall_hits = 0;
	int unsigned longest_read = 0;

	// Idling control, shared with the receiver process
	bit          idle_on    = 1'b1;
	bit          hold_req   = 1'b0;
	int unsigned hold_left  = 0;
	int unsigned burst_left = 0;

	i2c_master_register_access_sequencer i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.dev_addr   (dev_addr),
		.reg_addr   (reg_addr),
		.write_value(write_value),
		.read_len   (read_len),
		.flag_sb    (flag_sb),
		.flag_addr  (flag_addr),
		.flag_txe   (flag_txe),
		.flag_btf   (flag_btf),
		.flag_rxne  (flag_rxne),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.accepted   (accepted),
		.tx_valid   (tx_valid),
		.tx_data    (tx_data),
		.gen_start  (gen_start),
		.gen_stop   (gen_stop),
		.ack_action (ack_action),
		.rx_valid   (rx_valid),
		.rx_data    (rx_data),
		.rx_index   (rx_index),
		.done_res   (done_res),
		.busy_out   (busy_out)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Sequencer model: one request in, one expected action out.
	// Start requests are only taken when idle; each flag event moves the
	// phase on by at most one step, and only if the awaited flag is set.
	// ------------------------------------------------------------------------
	function automatic xfer_action_t advance_sequencer(input seq_req_t r);
		xfer_action_t res;
		logic [8:0]   next_count;
		res.accepted  = 1'b0;
		res.tx_valid  = 1'b0;
		res.tx_data   = 8'h00;
		res.gen_start = 1'b0;
		res.gen_stop  = 1'b0;
		res.ack       = i2c_mras_pkg::ACK_KEEP;
		res.rx_valid  = 1'b0;
		res.rx_data   = 8'h00;
		res.rx_index  = 8'h00;
		res.done      = 1'b0;
		case (r.func)
			i2c_mras_pkg::FUNC_START_WR: begin
				if (!seq_busy) begin
					dev_byte  = r.dev_addr;
					reg_byte  = r.reg_addr;
					wr_byte   = r.write_value;
					len_total = 8'd1;
					rd_mode   = 1'b0;
					rx_count  = 8'd0;
					seq_phase = i2c_mras_pkg::PH_START;
					seq_busy  = 1'b1;
					res.accepted  = 1'b1;
					res.gen_start = 1'b1;
				end
			end
			i2c_mras_pkg::FUNC_START_RD: begin
				// zero length and over-long reads are refused
				if (!seq_busy && r.read_len != 8'd0 &&
						16'(r.read_len) <= i2c_mras_pkg::MAX_READ_LEN) begin
					dev_byte  = r.dev_addr;
					reg_byte  = r.reg_addr;
					len_total = r.read_len;
					rd_mode   = 1'b1;
					rx_count  = 8'd0;
					seq_phase = i2c_mras_pkg::PH_START;
					seq_busy  = 1'b1;
					res.accepted  = 1'b1;
					res.gen_start = 1'b1;
				end
			end
			i2c_mras_pkg::FUNC_EVENT: begin
				case (seq_phase)
					i2c_mras_pkg::PH_START: if (r.flags & FL_SB) begin
						res.tx_valid = 1'b1;
						res.tx_data  = dev_byte;
						seq_phase    = i2c_mras_pkg::PH_ADDR_W;
					end
					i2c_mras_pkg::PH_ADDR_W: if (r.flags & FL_ADDR)
						seq_phase = i2c_mras_pkg::PH_REG;
					i2c_mras_pkg::PH_REG: if (r.flags & FL_TXE) begin
						res.tx_valid = 1'b1;
						res.tx_data  = reg_byte;
						seq_phase    = rd_mode ? i2c_mras_pkg::PH_RESTART
							: i2c_mras_pkg::PH_WDATA;
					end
					i2c_mras_pkg::PH_WDATA: if (r.flags & FL_BTF) begin
						res.tx_valid = 1'b1;
						res.tx_data  = wr_byte;
						seq_phase    = i2c_mras_pkg::PH_STOP;
					end
					i2c_mras_pkg::PH_RESTART: if (r.flags & FL_BTF) begin
						res.gen_start = 1'b1;
						seq_phase     = i2c_mras_pkg::PH_ADDR_R;
					end
					i2c_mras_pkg::PH_ADDR_R: if (r.flags & FL_SB) begin
						// read direction: bit0 forced high whatever was given
						res.tx_valid = 1'b1;
						res.tx_data  = dev_byte | 8'h01;
						seq_phase    = i2c_mras_pkg::PH_ADDR_R_WAIT;
					end
					i2c_mras_pkg::PH_ADDR_R_WAIT: if (r.flags & FL_ADDR) begin
						// single-byte read: NACK and stop go out right away
						if (len_total == 8'd1) begin
							res.ack      = i2c_mras_pkg::ACK_OFF;
							res.gen_stop = 1'b1;
						end else begin
							res.ack = i2c_mras_pkg::ACK_ON;
						end
						seq_phase = i2c_mras_pkg::PH_READ;
					end
					i2c_mras_pkg::PH_READ: if (r.flags & FL_RXNE) begin
						res.rx_valid = 1'b1;
						res.rx_data  = r.rx_byte;
						res.rx_index = rx_count;
						next_count   = {1'b0, rx_count} + 9'd1;
						rx_count     = next_count[7:0];
						// one byte left: NACK and stop ahead of it
						if ({1'b0, rx_count} + 9'd1 == {1'b0, len_total}) begin
							res.ack      = i2c_mras_pkg::ACK_OFF;
							res.gen_stop = 1'b1;
						end
						if (rx_count >= len_total) begin
							res.ack   = i2c_mras_pkg::ACK_ON;
							res.done  = 1'b1;
							seq_busy  = 1'b0;
							seq_phase = i2c_mras_pkg::PH_IDLE;
							reads_done++;
							if (len_total > longest_read) longest_read = len_total;
						end
					end
					i2c_mras_pkg::PH_STOP: if (r.flags & FL_BTF) begin
						res.gen_stop = 1'b1;
						res.ack      = i2c_mras_pkg::ACK_ON;
						res.done     = 1'b1;
						seq_busy     = 1'b0;
						seq_phase    = i2c_mras_pkg::PH_IDLE;
						writes_done++;
					end
					default: ;
				endcase
			end
			default: ;   // unused code: no action
		endcase
		res.busy = seq_busy;
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// Request builders
	// ------------------------------------------------------------------------
	function automatic seq_req_t random_req(input i2c_mras_pkg::func_t f);
		seq_req_t r;
		r.func        = f;
		r.dev_addr    = 8'($urandom);
		r.reg_addr    = 8'($urandom);
		r.write_value = 8'($urandom);
		r.read_len    = 8'($urandom);
		r.flags       = 5'($urandom);
		r.rx_byte     = 8'($urandom);
		return r;
	endfunction

	function automatic seq_req_t start_req(input i2c_mras_pkg::func_t f,
			input logic [7:0] dev, input logic [7:0] reg_a, input logic [7:0] val,
			input logic [7:0] len);
		seq_req_t r;
		r.func        = f;
		r.dev_addr    = dev;
		r.reg_addr    = reg_a;
		r.write_value = val;
		r.read_len    = len;
		r.flags       = 5'b00000;
		r.rx_byte     = 8'h00;
		return r;
	endfunction

	function automatic seq_req_t event_req(input logic [4:0] flags, input logic [7:0] rxb);
		seq_req_t r;
		r         = start_req(i2c_mras_pkg::FUNC_EVENT, 8'h00, 8'h00, 8'h00, 8'h00);
		r.flags   = flags;
		r.rx_byte = rxb;
		return r;
	endfunction

	// Random event with the flag the current phase waits for forced on (hit)
	// or off (stray event that must not move anything).
	function automatic seq_req_t flag_event(input bit hit);
		seq_req_t   r;
		logic [4:0] awaited;
		r = random_req(i2c_mras_pkg::FUNC_EVENT);
		case (seq_phase)
			i2c_mras_pkg::PH_START, i2c_mras_pkg::PH_ADDR_R:
				awaited = FL_SB;
			i2c_mras_pkg::PH_ADDR_W, i2c_mras_pkg::PH_ADDR_R_WAIT:
				awaited = FL_ADDR;
			i2c_mras_pkg::PH_REG:
				awaited = FL_TXE;
			i2c_mras_pkg::PH_WDATA, i2c_mras_pkg::PH_RESTART, i2c_mras_pkg::PH_STOP:
				awaited = FL_BTF;
			i2c_mras_pkg::PH_READ:
				awaited = FL_RXNE;
			default:
				awaited = 5'b00000;
		endcase
		r.flags = hit ? (r.flags | awaited) : (r.flags & ~awaited);
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Request driver. Entered and left at a falling edge; valid is only
	// lowered when a gap is taken, so it never toggles within one step.
	// ------------------------------------------------------------------------
	task automatic send_req(input seq_req_t r);
		xfer_action_t res;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		func        <= r.func;
		dev_addr    <= r.dev_addr;
		reg_addr    <= r.reg_addr;
		write_value <= r.write_value;
		read_len    <= r.read_len;
		{flag_sb, flag_addr, flag_txe, flag_btf, flag_rxne} <= r.flags;
		rx_byte     <= r.rx_byte;
		in_valid    <= 1'b1;
		@(posedge clk);
		while (in_stall) begin
			in_stall_hits++;
			@(posedge clk);
		end
		res = advance_sequencer(r);
		expected_actions.push_back(res);
		reqs_sent++;
		@(negedge clk);
	endtask

	// Sender stops and waits until every expected result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_actions.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// One transaction from start to completion, with some stray events,
	// refused starts and unused codes mixed in while it is busy.
	task automatic run_transaction(input bit is_read, input logic [7:0] len,
			input int unsigned noise_pct);
		seq_req_t    r;
		int unsigned pick;
		r = random_req(is_read ? i2c_mras_pkg::FUNC_START_RD : i2c_mras_pkg::FUNC_START_WR);
		r.read_len = len;
		send_req(r);
		while (seq_busy) begin
			pick = $urandom_range(0, 99);
			if (pick < noise_pct)
				r = flag_event(1'b0);
			else if (pick < noise_pct + 3)
				r = random_req(i2c_mras_pkg::func_t'($urandom_range(0, 1)));
			else if (pick < noise_pct + 5)
				r = random_req(i2c_mras_pkg::FUNC_UNUSED);
			else
				r = flag_event(1'b1);
			send_req(r);
		end
	endtask

	// ------------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------------
	task automatic report_mismatch(input string what);
		mismatches++;
		$display("tb: mismatch at %0t ns: %s", $time, what);
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s = %0h, expected %0h",
				results_seen, name, got, want));
	endtask

	always @(posedge clk) begin : result_check
		xfer_action_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_actions.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				want = expected_actions.pop_front();
				check_field("accepted",   8'(accepted),   8'(want.accepted));
				check_field("tx_valid",   8'(tx_valid),   8'(want.tx_valid));
				check_field("tx_data",    tx_data,        want.tx_data);
				check_field("gen_start",  8'(gen_start),  8'(want.gen_start));
				check_field("gen_stop",   8'(gen_stop),   8'(want.gen_stop));
				check_field("ack_action", 8'(ack_action), 8'(want.ack));
				check_field("rx_valid",   8'(rx_valid),   8'(want.rx_valid));
				check_field("rx_data",    rx_data,        want.rx_data);
				check_field("rx_index",   rx_index,       want.rx_index);
				check_field("done_res",   8'(done_res),   8'(want.done));
				check_field("busy_out",   8'(busy_out),   8'(want.busy));
			end
			results_seen++;
		end
	end

	// ------------------------------------------------------------------------
	// Receiver stall. A requested hold-off takes priority over the random
	// bursts; it is counted down here, one cycle per falling edge.
	// ------------------------------------------------------------------------
	initial begin : result_stall
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else if (burst_left > 0) begin
				out_stall <= 1'b1;
				burst_left--;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				burst_left = $urandom_range(1, 19) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Write path with a device address that has bit0 set (sent unchanged),
	// plus the refusals: zero length, starts while busy, idle events, code 3.
	task automatic test_write_path();
		seq_req_t r;
		send_req(event_req(FL_ALL, 8'hFF));          // idle: no action
		r = start_req(i2c_mras_pkg::FUNC_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		r.flags   = FL_ALL;
		r.rx_byte = 8'hFF;
		send_req(r);
		send_req(start_req(i2c_mras_pkg::FUNC_START_RD, 8'hA0, 8'h10, 8'h00, 8'h00));
		send_req(start_req(i2c_mras_pkg::FUNC_START_WR, 8'hFF, 8'h00, 8'hFF, 8'h00));
		send_req(start_req(i2c_mras_pkg::FUNC_START_WR, 8'h00, 8'h00, 8'h00, 8'h00));
		send_req(start_req(i2c_mras_pkg::FUNC_START_RD, 8'h00, 8'h00, 8'h00, 8'h01));
		send_req(event_req(FL_ALL & ~FL_SB, 8'h00));  // awaited flag missing
		send_req(event_req(FL_SB, 8'h00));
		send_req(event_req(FL_ADDR, 8'h00));
		send_req(event_req(FL_TXE, 8'h00));
		send_req(event_req(FL_BTF, 8'h00));
		send_req(event_req(FL_BTF, 8'h00));           // stop and done
	endtask

	// Single-byte read: NACK and stop at the read address acknowledge
	task automatic test_single_byte_read();
		send_req(start_req(i2c_mras_pkg::FUNC_START_RD, 8'h00, 8'hFF, 8'h00, 8'h01));
		send_req(event_req(FL_SB, 8'h00));
		send_req(event_req(FL_ADDR, 8'h00));
		send_req(event_req(FL_TXE, 8'h00));
		send_req(event_req(FL_BTF, 8'h00));           // repeated start
		send_req(event_req(FL_SB, 8'h00));            // address | read bit
		send_req(event_req(FL_ADDR, 8'h00));
		send_req(event_req(FL_RXNE, 8'hA5));
	endtask

	// Two-byte read (stop after the first byte) and a maximum-length read
	task automatic test_read_lengths();
		run_transaction(1'b1, 8'd2, 0);
		run_transaction(1'b1, 8'hFF, 10);
	endtask

	// Receiver holds off for a long stretch while requests keep coming, so
	// the pipeline fills and in_stall rises; then the sender waits for all
	// results before going on.
	task automatic test_backpressure();
		hold_req = 1'b1;
		run_transaction(1'b1, 8'd6, 0);
		run_transaction(1'b0, 8'd0, 0);
		drain_results();
		hold_req = 1'b1;
		run_transaction(1'b0, 8'd0, 20);
		drain_results();
	endtask

	// Mostly well-formed transactions with random content, the rest noise:
	// idle events, code 3, zero-length reads and starts that may leave a
	// transaction open for the next one to finish.
	task automatic test_random_traffic();
		int unsigned stop_at;
		int unsigned pick;
		seq_req_t    r;
		logic [7:0]  len;
		stop_at = reqs_sent + RANDOM_REQS;
		while (reqs_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				r = random_req(i2c_mras_pkg::func_t'($urandom_range(0, 3)));
				if ($urandom_range(0, 1)) r.read_len = 8'd0;
				send_req(r);
			end else if (pick < 60) begin
				pick = $urandom_range(0, 99);
				if (pick < 70)      len = 8'($urandom_range(1, 6));
				else if (pick < 97) len = 8'($urandom_range(7, 32));
				else                len = 8'($urandom_range(100, 255));
				run_transaction(1'b1, len, 15);
			end else begin
				run_transaction(1'b0, 8'd0, 15);
			end
			if ($urandom_range(0, 29) == 0) drain_results();
		end
	endtask

	// Back-to-back traffic with no idling on either side
	task automatic test_quiet_tail();
		idle_on = 1'b0;
		run_transaction(1'b0, 8'd0, 0);
		run_transaction(1'b1, 8'd3, 0);
		run_transaction(1'b1, 8'd1, 10);
		run_transaction(1'b0, 8'd0, 10);
		run_transaction(1'b1, 8'd8, 10);
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		func        = i2c_mras_pkg::FUNC_EVENT;
		dev_addr    = 8'h00;
		reg_addr    = 8'h00;
		write_value = 8'h00;
		read_len    = 8'h00;
		{flag_sb, flag_addr, flag_txe, flag_btf, flag_rxne} = 5'b00000;
		rx_byte     = 8'h00;
		seq_phase   = i2c_mras_pkg::PH_IDLE;
		dev_byte    = 8'h00;
		reg_byte    = 8'h00;
		wr_byte     = 8'h00;
		len_total   = 8'h00;
		rx_count    = 8'h00;
		rd_mode     = 1'b0;
		seq_busy    = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_write_path();
		test_single_byte_read();
		test_read_lengths();
		test_backpressure();
		test_random_traffic();
		test_quiet_tail();

		drain_results();
		repeat (SETTLE) @(posedge clk);

		$display("tb: %0d requests, %0d results checked, %0d reads and %0d writes completed",
			reqs_sent, results_seen, reads_done, writes_done);
		$display("tb: longest read %0d bytes, input held off on %0d cycles",
			longest_read, in_stall_hits);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Watchdog: a hung handshake or a missing result ends here
	initial begin
		#(LIMIT_CYCLES * 2 * CLK_HALF);
		$display("tb: failure");
		$finish;
	end

endmodule
